// File: src/tlsshc_pkg.sv
// Shared types, constants and helpers for the TLS ServerHello checker.
// No dependencies; used by tls_server_hello_checker_core.
package tlsshc_pkg;

  localparam int unsigned MAX_BYTES_DEF = 2048;

  // TLS framing
  localparam logic [7:0] REC_ALERT       = 8'd21;
  localparam logic [7:0] REC_HANDSHAKE   = 8'd22;
  localparam logic [7:0] HS_SERVER_HELLO = 8'd2;
  localparam logic [7:0] TLS_MAJOR       = 8'd3;
  localparam int unsigned HDR_LEN      = 9;
  localparam int unsigned MIN_BODY_END = 45;
  localparam int unsigned SID_POS      = 43;

  // byte offsets inside the record
  localparam int unsigned POS_REC_TYPE = 0;
  localparam int unsigned POS_BYTE5    = 5;
  localparam int unsigned POS_LEN_HI   = 6;
  localparam int unsigned POS_LEN_MID  = 7;
  localparam int unsigned POS_LEN_LO   = 8;
  localparam int unsigned POS_MAJOR    = 9;
  localparam int unsigned POS_MINOR    = 10;

  // verdict codes
  localparam logic [2:0] STATUS_OK         = 3'd0;
  localparam logic [2:0] STATUS_TOO_SHORT  = 3'd1;
  localparam logic [2:0] STATUS_ALERT      = 3'd2;
  localparam logic [2:0] STATUS_BAD_RECORD = 3'd3;
  localparam logic [2:0] STATUS_NOT_HELLO  = 3'd4;
  localparam logic [2:0] STATUS_INCOMPLETE = 3'd5;
  localparam logic [2:0] STATUS_BAD_SID    = 3'd6;

  localparam logic [2:0] CIPHER_UNKNOWN = 3'd0;
  localparam logic [2:0] VERSION_UNKNOWN = 3'd0;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  version_major;
    logic [7:0]  version_minor;
    logic [2:0]  version_code;
    logic [15:0] cipher_suite;
    logic [2:0]  cipher_code;
    logic [7:0]  detail_first;
    logic [7:0]  detail_second;
  } verdict_t;

  // known suites, code is index + 1
  function automatic logic [2:0] cipher_code_of(input logic [15:0] suite);
    logic [2:0] code;
    code = CIPHER_UNKNOWN;
    unique case (suite)
      16'hc02f: code = 3'd1;
      16'hc02b: code = 3'd2;
      16'hc027: code = 3'd3;
      16'hc023: code = 3'd4;
      16'h009c: code = 3'd5;
      16'h003c: code = 3'd6;
      default:  code = CIPHER_UNKNOWN;
    endcase
    return code;
  endfunction

  function automatic logic [2:0] version_code_of(input logic [7:0] major,
                                                 input logic [7:0] minor);
    logic [2:0] code;
    code = VERSION_UNKNOWN;
    if (major == TLS_MAJOR && minor >= 8'd1 && minor <= 8'd4) begin
      code = minor[2:0];
    end
    return code;
  endfunction

endpackage

// File: src/tls_server_hello_checker_core.sv
// TLS ServerHello checker, top level.
// Depends on tlsshc_pkg (types, codes, suite and version lookup).
//
// Usage:
//   req channel (req_valid/req_ready/req_data) carries the received response
//   one byte per transfer; last_byte marks the final byte of the buffer.
//   verdict channel (verdict_valid/verdict_ready/verdict_data) carries one
//   verdict per buffer, for the transfer that had last_byte set.
// Throughput: one byte per cycle, but for a stalled last byte. Each byte only
//   bumps the position counter and captures header fields, so the counter update is the loop.
// Latency: the verdict is valid in the cycle after the last byte transfer,
//   from a single output register.
// Stall: while a verdict waits, non-last bytes of the next buffer are still
//   taken; a last byte waits until the pending verdict is taken (or is taken
//   in the same cycle).
// Bytes past MAX_BYTES are accepted but neither counted nor captured.
// Reset (rst, synchronous): clears the counter, captured fields and the
//   verdict valid. State also clears after each verdict.
module tls_server_hello_checker_core #(
  parameter int unsigned MAX_BYTES = tlsshc_pkg::MAX_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  tlsshc_pkg::req_t     req_data,
  output logic                 verdict_valid,
  input  logic                 verdict_ready,
  output tlsshc_pkg::verdict_t verdict_data
);

  localparam int unsigned POS_W = $clog2(MAX_BYTES + 1);
  localparam int unsigned CPOS_W = (POS_W > 10) ? POS_W : 10;
  localparam int unsigned END_W = 25;

  logic [POS_W-1:0] pos, pos_next;
  logic [7:0]  rec_type, rec_type_next;
  logic [7:0]  byte5, byte5_next;
  logic [23:0] body_len, body_len_next;
  logic [7:0]  major, major_next;
  logic [7:0]  minor, minor_next;
  logic [7:0]  sid_len, sid_len_next;
  logic [15:0] cipher, cipher_next;

  logic                 take;
  logic                 in_range;
  logic [CPOS_W-1:0]    pos_ext;
  logic [CPOS_W-1:0]    cpos;
  logic [END_W-1:0]     len_ext;
  logic [END_W-1:0]     hello_end;
  logic [END_W-1:0]     sid_end;
  tlsshc_pkg::verdict_t verdict_next;

  assign req_ready = !verdict_valid || verdict_ready || !req_data.last_byte;
  assign take      = req_valid && req_ready;
  assign in_range  = pos < POS_W'(MAX_BYTES);
  assign pos_ext   = CPOS_W'(pos);
  assign cpos      = CPOS_W'(tlsshc_pkg::SID_POS + 1) + CPOS_W'(sid_len);

  // capture
  always_comb begin
    pos_next      = pos;
    rec_type_next = rec_type;
    byte5_next    = byte5;
    body_len_next = body_len;
    major_next    = major;
    minor_next    = minor;
    sid_len_next  = sid_len;
    cipher_next   = cipher;
    if (in_range) begin
      pos_next = pos + POS_W'(1);
      if (pos == POS_W'(tlsshc_pkg::POS_REC_TYPE)) rec_type_next = req_data.byte_value;
      if (pos == POS_W'(tlsshc_pkg::POS_BYTE5))    byte5_next = req_data.byte_value;
      if (pos == POS_W'(tlsshc_pkg::POS_LEN_HI))   body_len_next[23:16] = req_data.byte_value;
      if (pos == POS_W'(tlsshc_pkg::POS_LEN_MID))  body_len_next[15:8] = req_data.byte_value;
      if (pos == POS_W'(tlsshc_pkg::POS_LEN_LO))   body_len_next[7:0] = req_data.byte_value;
      if (pos == POS_W'(tlsshc_pkg::POS_MAJOR))    major_next = req_data.byte_value;
      if (pos == POS_W'(tlsshc_pkg::POS_MINOR))    minor_next = req_data.byte_value;
      if (pos == POS_W'(tlsshc_pkg::SID_POS))      sid_len_next = req_data.byte_value;
      if (pos_ext > CPOS_W'(tlsshc_pkg::SID_POS)) begin
        if (pos_ext == cpos)               cipher_next[15:8] = req_data.byte_value;
        if (pos_ext == cpos + CPOS_W'(1))  cipher_next[7:0] = req_data.byte_value;
      end
    end
  end

  // verdict from the state as it stands after this byte
  assign len_ext   = END_W'(pos_next);
  assign hello_end = END_W'(tlsshc_pkg::HDR_LEN) + END_W'(body_len_next);
  assign sid_end   = END_W'(tlsshc_pkg::SID_POS + 4) + END_W'(sid_len_next);

  always_comb begin
    verdict_next = '0;
    priority if (len_ext < END_W'(tlsshc_pkg::HDR_LEN)) begin
      verdict_next.status = tlsshc_pkg::STATUS_TOO_SHORT;
    end else if (rec_type_next == tlsshc_pkg::REC_ALERT) begin
      verdict_next.status        = tlsshc_pkg::STATUS_ALERT;
      verdict_next.detail_first  = byte5_next;
      verdict_next.detail_second = body_len_next[23:16];
    end else if (rec_type_next != tlsshc_pkg::REC_HANDSHAKE) begin
      verdict_next.status       = tlsshc_pkg::STATUS_BAD_RECORD;
      verdict_next.detail_first = rec_type_next;
    end else if (byte5_next != tlsshc_pkg::HS_SERVER_HELLO) begin
      verdict_next.status       = tlsshc_pkg::STATUS_NOT_HELLO;
      verdict_next.detail_first = byte5_next;
    end else if (hello_end > len_ext || hello_end < END_W'(tlsshc_pkg::MIN_BODY_END)) begin
      verdict_next.status = tlsshc_pkg::STATUS_INCOMPLETE;
    end else if (sid_end > hello_end) begin
      verdict_next.status = tlsshc_pkg::STATUS_BAD_SID;
    end else begin
      verdict_next.status        = tlsshc_pkg::STATUS_OK;
      verdict_next.version_major = major_next;
      verdict_next.version_minor = minor_next;
      verdict_next.version_code  = tlsshc_pkg::version_code_of(major_next, minor_next);
      verdict_next.cipher_suite  = cipher_next;
      verdict_next.cipher_code   = tlsshc_pkg::cipher_code_of(cipher_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      rec_type <= '0;
      byte5    <= '0;
      body_len <= '0;
      major    <= '0;
      minor    <= '0;
      sid_len  <= '0;
      cipher   <= '0;
    end else if (take) begin
      if (req_data.last_byte) begin
        pos      <= '0;
        rec_type <= '0;
        byte5    <= '0;
        body_len <= '0;
        major    <= '0;
        minor    <= '0;
        sid_len  <= '0;
        cipher   <= '0;
      end else begin
        pos      <= pos_next;
        rec_type <= rec_type_next;
        byte5    <= byte5_next;
        body_len <= body_len_next;
        major    <= major_next;
        minor    <= minor_next;
        sid_len  <= sid_len_next;
        cipher   <= cipher_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
    end else if (take && req_data.last_byte) begin
      verdict_valid <= 1'b1;
    end else if (verdict_ready) begin
      verdict_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && req_data.last_byte) begin
      verdict_data <= verdict_next;
    end
  end

  // a last-byte transfer always yields a verdict next cycle
  a_last_gives_verdict: assert property (@(posedge clk) disable iff (rst)
    (take && req_data.last_byte) |=> verdict_valid)
    else $error("verdict missing after last byte");

  // state starts over after a verdict
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (take && req_data.last_byte) |=> (pos == '0 && sid_len == '0 && cipher == '0))
    else $error("state not cleared after verdict");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_W'(MAX_BYTES))
    else $error("position beyond buffer size");

  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    (take && !req_data.last_byte) |=> (pos == ($past(in_range) ? $past(pos) + POS_W'(1)
                                                               : $past(pos))))
    else $error("position counter step wrong");

  // payload fields only on ok
  a_fields_on_ok: assert property (@(posedge clk) disable iff (rst)
    (verdict_valid && verdict_data.status != tlsshc_pkg::STATUS_OK) |->
      (verdict_data.cipher_suite == '0 && verdict_data.version_major == '0 &&
       verdict_data.cipher_code == tlsshc_pkg::CIPHER_UNKNOWN))
    else $error("version or cipher set on failing verdict");

endmodule

// File: tb/tls_hello_verdict_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the TLS ServerHello checker: tracks byte transfers, predicts each verdict.
// Depends on tlsshc_pkg; instantiated beside tls_server_hello_checker_core by testbench.
module tls_hello_verdict_checker #(
  parameter int unsigned BUF_LIMIT = tlsshc_pkg::MAX_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  logic                 req_ready,
  input  tlsshc_pkg::req_t     req_data,
  input  logic                 verdict_valid,
  input  logic                 verdict_ready,
  input  tlsshc_pkg::verdict_t verdict_data,
  output int                   failures,
  output int                   verdicts_owed,
  output int                   verdicts_checked,
  output int                   bytes_taken
);
  import tlsshc_pkg::*;

  // code of a recognized suite is its index + 1
  localparam logic [5:0][15:0] SUITES =
    {16'h003c, 16'h009c, 16'hc023, 16'hc027, 16'hc02b, 16'hc02f};

  int unsigned taken_pos;
  logic [7:0]  rec_type;
  logic [7:0]  fifth;
  logic [23:0] body_len;
  logic [7:0]  major_seen;
  logic [7:0]  minor_seen;
  logic [7:0]  sid_len;
  logic [15:0] suite_seen;

  verdict_t verdicts_due[$];
  int fail_total = 0;
  int owed = 0;
  int checked = 0;
  int byte_total = 0;

  assign failures = fail_total;
  assign verdicts_owed = owed;
  assign verdicts_checked = checked;
  assign bytes_taken = byte_total;

  task automatic clear_capture();
    taken_pos = 0;
    rec_type = '0;
    fifth = '0;
    body_len = '0;
    major_seen = '0;
    minor_seen = '0;
    sid_len = '0;
    suite_seen = '0;
  endtask

  task automatic absorb_byte(input req_t item);
    verdict_t want;
    int unsigned cipher_at;
    int unsigned hello_end;
    // past the buffer size bytes still end a buffer but are not captured
    if (taken_pos < BUF_LIMIT) begin
      cipher_at = SID_POS + 1 + sid_len;
      if (taken_pos == POS_REC_TYPE) rec_type = item.byte_value;
      if (taken_pos == POS_BYTE5) fifth = item.byte_value;
      if (taken_pos == POS_LEN_HI) body_len[23:16] = item.byte_value;
      if (taken_pos == POS_LEN_MID) body_len[15:8] = item.byte_value;
      if (taken_pos == POS_LEN_LO) body_len[7:0] = item.byte_value;
      if (taken_pos == POS_MAJOR) major_seen = item.byte_value;
      if (taken_pos == POS_MINOR) minor_seen = item.byte_value;
      if (taken_pos == SID_POS) sid_len = item.byte_value;
      if (taken_pos > SID_POS && taken_pos == cipher_at) suite_seen[15:8] = item.byte_value;
      if (taken_pos > SID_POS && taken_pos == cipher_at + 1) suite_seen[7:0] = item.byte_value;
      taken_pos++;
    end
    if (!item.last_byte) return;

    want = '0;
    hello_end = HDR_LEN + body_len;
    if (taken_pos < HDR_LEN) begin
      want.status = STATUS_TOO_SHORT;
    end else if (rec_type == REC_ALERT) begin
      want.status = STATUS_ALERT;
      want.detail_first = fifth;
      want.detail_second = body_len[23:16];
    end else if (rec_type != REC_HANDSHAKE) begin
      want.status = STATUS_BAD_RECORD;
      want.detail_first = rec_type;
    end else if (fifth != HS_SERVER_HELLO) begin
      want.status = STATUS_NOT_HELLO;
      want.detail_first = fifth;
    end else if (hello_end > taken_pos || hello_end < MIN_BODY_END) begin
      want.status = STATUS_INCOMPLETE;
    end else if (SID_POS + 4 + sid_len > hello_end) begin
      // session id plus cipher pair and compression byte must fit in the body
      want.status = STATUS_BAD_SID;
    end else begin
      want.status = STATUS_OK;
      want.version_major = major_seen;
      want.version_minor = minor_seen;
      if (major_seen == TLS_MAJOR && minor_seen >= 8'd1 && minor_seen <= 8'd4) begin
        want.version_code = minor_seen[2:0];
      end
      want.cipher_suite = suite_seen;
      for (int k = 0; k < 6; k++) begin
        if (suite_seen == SUITES[k]) want.cipher_code = 3'(k + 1);
      end
    end
    verdicts_due.push_back(want);
    clear_capture();
  endtask

  task automatic compare_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      fail_total++;
    end
  endtask

  task automatic check_verdict(input verdict_t want, input verdict_t got);
    compare_field("status", 16'(want.status), 16'(got.status));
    compare_field("version_major", 16'(want.version_major), 16'(got.version_major));
    compare_field("version_minor", 16'(want.version_minor), 16'(got.version_minor));
    compare_field("version_code", 16'(want.version_code), 16'(got.version_code));
    compare_field("cipher_suite", want.cipher_suite, got.cipher_suite);
    compare_field("cipher_code", 16'(want.cipher_code), 16'(got.cipher_code));
    compare_field("detail_first", 16'(want.detail_first), 16'(got.detail_first));
    compare_field("detail_second", 16'(want.detail_second), 16'(got.detail_second));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_capture();
      verdicts_due.delete();
    end else begin
      if (verdict_valid && verdict_ready) begin
        if (verdicts_due.size() == 0) begin
          $error("verdict transfer with nothing expected, status 0x%0h", verdict_data.status);
          fail_total++;
        end else begin
          check_verdict(verdicts_due.pop_front(), verdict_data);
          checked++;
        end
      end
      if (req_valid && req_ready) begin
        absorb_byte(req_data);
        byte_total++;
      end
    end
    owed = verdicts_due.size();
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Top of the ServerHello checker bench: clock, reset, byte stimulus and verdict pacing.
// Depends on tlsshc_pkg, tls_server_hello_checker_core and tls_hello_verdict_checker.
module testbench;
  import tlsshc_pkg::*;

  localparam int unsigned BUF_LIMIT = MAX_BYTES_DEF;
  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [5:0][15:0] SUITES =
    {16'h003c, 16'h009c, 16'hc023, 16'hc027, 16'hc02b, 16'hc02f};
  // pacing mixes for the random part: sender idle and receiver stall, percent
  localparam int IDLE_PLAN [4] = '{0, 85, 0, 31};
  localparam int STALL_PLAN [4] = '{0, 0, 85, 31};

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_ready;
  req_t     req_data = '0;
  logic     verdict_valid;
  logic     verdict_ready = 1'b0;
  verdict_t verdict_data;

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int hold_orders = 0;
  int hold_served = 0;
  int hold_left = 0;
  int unsigned cycles = 0;
  int bytes_sent = 0;
  int frames_sent = 0;
  int failures, verdicts_owed, verdicts_checked, bytes_taken;
  logic [7:0] frame[$];

  tls_server_hello_checker_core uut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .req_data     (req_data),
    .verdict_valid(verdict_valid),
    .verdict_ready(verdict_ready),
    .verdict_data (verdict_data)
  );

  tls_hello_verdict_checker #(.BUF_LIMIT(BUF_LIMIT)) scoreboard (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_ready       (req_ready),
    .req_data        (req_data),
    .verdict_valid   (verdict_valid),
    .verdict_ready   (verdict_ready),
    .verdict_data    (verdict_data),
    .failures        (failures),
    .verdicts_owed   (verdicts_owed),
    .verdicts_checked(verdicts_checked),
    .bytes_taken     (bytes_taken)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout: %0d cycles, %0d verdicts outstanding", cycles, verdicts_owed);
      $display("status: fail");
      $finish;
    end
  end

  // verdict side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      verdict_ready <= 1'b0;
    end else begin
      if (hold_orders != hold_served) begin
        hold_served = hold_orders;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        verdict_ready <= 1'b0;
      end else begin
        verdict_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] value, input logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data <= '{byte_value: value, last_byte: last};
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1);
    frames_sent++;
  endtask

  task automatic noise_frame(input int count);
    frame.delete();
    repeat (count) frame.push_back(8'($urandom));
  endtask

  task automatic set_body_len(input logic [23:0] len);
    frame[POS_LEN_HI] = len[23:16];
    frame[POS_LEN_MID] = len[15:8];
    frame[POS_LEN_LO] = len[7:0];
  endtask

  // well-formed ServerHello; body ends between the compression byte and the last byte
  task automatic build_hello(input int sid, input int tail, input logic [15:0] suite,
                             input logic [7:0] major, input logic [7:0] minor);
    int total;
    total = SID_POS + 4 + sid + tail;
    noise_frame(total);
    frame[POS_REC_TYPE] = REC_HANDSHAKE;
    frame[POS_BYTE5] = HS_SERVER_HELLO;
    frame[POS_MAJOR] = major;
    frame[POS_MINOR] = minor;
    frame[SID_POS] = 8'(sid);
    frame[SID_POS + 1 + sid] = suite[15:8];
    frame[SID_POS + 2 + sid] = suite[7:0];
    set_body_len(24'(total - $urandom_range(tail, 0) - HDR_LEN));
  endtask

  function automatic logic [15:0] pick_suite();
    if ($urandom_range(9) < 7) return SUITES[$urandom_range(5)];
    return 16'($urandom);
  endfunction

  task automatic random_hello();
    int sid;
    logic [7:0] major, minor;
    sid = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(40);
    major = ($urandom_range(4) == 0) ? 8'($urandom) : TLS_MAJOR;
    minor = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(5));
    build_hello(sid, $urandom_range(12), pick_suite(), major, minor);
  endtask

  task automatic random_frame();
    int pick, cut, sid;
    pick = $urandom_range(99);
    if (pick < 55) begin
      random_hello();
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(2))
          0: frame[$urandom_range(frame.size() - 1)] = 8'($urandom);
          1: begin
            cut = $urandom_range(frame.size() - 1, 1);
            repeat (cut) void'(frame.pop_back());
          end
          default: set_body_len(24'($urandom));
        endcase
      end
    end else if (pick < 65) begin
      // body ends inside the session id or before the compression byte
      sid = $urandom_range(60, 2);
      build_hello(sid, $urandom_range(8), pick_suite(), TLS_MAJOR, 8'($urandom_range(4, 1)));
      set_body_len(24'($urandom_range(SID_POS + 3 + sid, MIN_BODY_END) - HDR_LEN));
    end else if (pick < 75) begin
      noise_frame($urandom_range(20, 9));
      frame[POS_REC_TYPE] = REC_ALERT;
    end else if (pick < 85) begin
      random_hello();
      frame[POS_BYTE5] = 8'($urandom);
    end else if (pick < 93) begin
      noise_frame($urandom_range(60, 9));
    end else begin
      noise_frame($urandom_range(12, 1));
    end
  endtask

  initial begin
    logic [7:0] majors [8];
    logic [7:0] minors [8];
    logic [15:0] suite;
    int base_bytes, base_frames;

    majors = '{8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd2, 8'hff};
    minors = '{8'd1, 8'd2, 8'd3, 8'd4, 8'd0, 8'd5, 8'd1, 8'hff};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // too short: one byte, then one byte shy of the header
    noise_frame(1);
    send_frame();
    noise_frame(8);
    frame[POS_REC_TYPE] = REC_HANDSHAKE;
    send_frame();

    // alerts: ordinary level/description and all-ones
    frame = '{REC_ALERT, 8'h03, 8'h03, 8'h00, 8'h02, 8'h02, 8'h28, 8'h00, 8'h00};
    send_frame();
    noise_frame(12);
    frame[POS_REC_TYPE] = REC_ALERT;
    frame[POS_BYTE5] = 8'hff;
    frame[POS_LEN_HI] = 8'hff;
    send_frame();

    // record types other than handshake and alert
    foreach (minors[i]) begin
      if (i < 3) begin
        noise_frame(9);
        frame[POS_REC_TYPE] = (i == 0) ? 8'h00 : (i == 1) ? 8'h17 : 8'hff;
        send_frame();
      end
    end

    // handshake that is not a ServerHello
    build_hello(0, 3, SUITES[0], TLS_MAJOR, 8'd3);
    frame[POS_BYTE5] = 8'h01;
    send_frame();
    build_hello(0, 3, SUITES[0], TLS_MAJOR, 8'd3);
    frame[POS_BYTE5] = 8'hff;
    send_frame();

    // body longer than the buffer, and shorter than the minimum
    build_hello(0, 2, SUITES[1], TLS_MAJOR, 8'd3);
    set_body_len(24'hffffff);
    send_frame();
    build_hello(0, 2, SUITES[1], TLS_MAJOR, 8'd3);
    set_body_len(24'h000000);
    send_frame();

    // longest session id: body one short, then exactly enough
    build_hello(255, 0, SUITES[2], TLS_MAJOR, 8'd4);
    set_body_len(24'(frame.size() - 1 - HDR_LEN));
    send_frame();
    build_hello(255, 0, SUITES[2], TLS_MAJOR, 8'd4);
    set_body_len(24'(frame.size() - HDR_LEN));
    send_frame();

    // each recognized suite plus two unknown, across the version corners
    for (int i = 0; i < 8; i++) begin
      suite = (i < 6) ? SUITES[i] : (i == 6) ? 16'h0000 : 16'hffff;
      build_hello(i * 5, i, suite, majors[i], minors[i]);
      send_frame();
    end

    // buffers at and past the capture limit
    build_hello(32, BUF_LIMIT + 20 - SID_POS - 4 - 32, SUITES[3], TLS_MAJOR, 8'd3);
    set_body_len(24'(BUF_LIMIT - HDR_LEN));
    send_frame();
    build_hello(0, BUF_LIMIT + 1 - SID_POS - 4, SUITES[4], TLS_MAJOR, 8'd2);
    set_body_len(24'(BUF_LIMIT + 1 - HDR_LEN));
    send_frame();
    build_hello(0, BUF_LIMIT - SID_POS - 4, SUITES[5], TLS_MAJOR, 8'd1);
    set_body_len(24'(BUF_LIMIT - HDR_LEN));
    send_frame();

    // long verdict hold-off: short buffers wait behind the pending verdict
    hold_orders++;
    repeat (4) begin
      frame = '{REC_ALERT, 8'h02};
      send_frame();
    end
    random_hello();
    send_frame();

    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = IDLE_PLAN[ph];
      receiver_stall_pct = STALL_PLAN[ph];
      base_bytes = bytes_sent;
      base_frames = frames_sent;
      while (bytes_sent - base_bytes < 375 || frames_sent - base_frames < 12) begin
        random_frame();
        send_frame();
      end
    end

    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    req_valid <= 1'b0;
    while (verdicts_owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("run covered %0d bytes in %0d buffers, %0d verdicts compared", bytes_taken,
             frames_sent, verdicts_checked);
    $display("pacing: free flow, sender gaps, verdict stalls, both, and one long hold-off");
    // a verdict still owed here never came out of the block
    if (failures == 0 && verdicts_owed == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
src/tlsshc_pkg.sv
src/tls_server_hello_checker_core.sv
tb/tls_hello_verdict_checker.sv
tb/testbench.sv
